/* design/sedx_pkg.sv */
// Shared types and constants for the sync/escape deframer with XOR check.
// Used by the configuration registers, the result buffer and the top level.
package sedx_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET   = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FOLLOW_ESC  = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_FOLLOW_SYNC = 8'h02;

    localparam logic REG_SYNC_IDX   = 1'b0;
    localparam logic REG_ESCAPE_IDX = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] escape_value;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              is_last;
        logic              checksum_ok;
        logic              escape_fault;
    } res_t;

endpackage

/* design/sync_escape_deframer_xor_check.sv */
// Top level of the byte-stuffed frame deframer with XOR checksum test.
// Depends on sedx_pkg, sedx_cfg_regs and sedx_out_buf.
//
// The s_ channel takes one raw link byte per beat. Bytes are dropped until
// a sync byte opens a frame. Inside a frame escape pairs are undone and one
// byte is held back, so the checksum byte leaves on the m_ channel marked
// is_last, with checksum_ok and escape_fault valid on that beat only.
// The frame state updates at the input beat and the byte it releases is
// written into a two-entry result buffer, from which it is presented on m_.
// One byte is accepted every cycle while the buffer is not full.
// If the receiver stalls, the buffer absorbs two results and s_ready then
// drops until a result is taken. The APB port holds the sync value at
// address 0 and the escape value at address 4; writes take effect from the
// next byte. Reset (aresetn low, synchronous) restores both values to 0x7E
// and 0x7D, empties the buffer and returns to hunting for sync.
module sync_escape_deframer_xor_check
    import sedx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_raw_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_frame_byte,
    output logic              m_is_last,
    output logic              m_checksum_ok,
    output logic              m_escape_fault,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    res_t              res;
    res_t              rd_res;
    logic              res_valid;
    logic              buf_full;
    logic              in_beat;
    logic              have_data;
    logic [BYTE_W-1:0] data;

    logic              inside_reg,     inside_next;
    logic              esc_pend_reg,   esc_pend_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] held_byte_reg,  held_byte_next;
    logic [BYTE_W-1:0] xor_reg,        xor_next;
    logic              fault_reg,      fault_next;

    sedx_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = ~buf_full;
    assign in_beat = s_valid & s_ready;

    always_comb begin
        inside_next     = inside_reg;
        esc_pend_next   = esc_pend_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        xor_next        = xor_reg;
        fault_next      = fault_reg;
        res_valid       = 1'b0;
        res             = '0;
        have_data       = 1'b0;
        data            = s_raw_byte;
        if (in_beat) begin
            if (!inside_reg) begin
                if (s_raw_byte == cfg.sync_value) begin
                    inside_next     = 1'b1;
                    esc_pend_next   = 1'b0;
                    held_valid_next = 1'b0;
                    held_byte_next  = '0;
                    xor_next        = '0;
                    fault_next      = 1'b0;
                end
            end else if (s_raw_byte == cfg.sync_value) begin
                if (held_valid_reg) begin
                    res_valid        = 1'b1;
                    res.frame_byte   = held_byte_reg;
                    res.is_last      = 1'b1;
                    res.checksum_ok  = (xor_reg == '0);
                    res.escape_fault = fault_reg | esc_pend_reg;
                end
                inside_next     = 1'b0;
                esc_pend_next   = 1'b0;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
                xor_next        = '0;
                fault_next      = 1'b0;
            end else begin
                if (esc_pend_reg) begin
                    esc_pend_next = 1'b0;
                    case (s_raw_byte)
                        ESC_FOLLOW_ESC: begin
                            data      = cfg.escape_value;
                            have_data = 1'b1;
                        end
                        ESC_FOLLOW_SYNC: begin
                            data      = cfg.sync_value;
                            have_data = 1'b1;
                        end
                        default: begin
                            fault_next = 1'b1;
                        end
                    endcase
                end else if (s_raw_byte == cfg.escape_value) begin
                    esc_pend_next = 1'b1;
                end else begin
                    have_data = 1'b1;
                end
                if (have_data) begin
                    if (held_valid_reg) begin
                        res_valid      = 1'b1;
                        res.frame_byte = held_byte_reg;
                    end
                    held_byte_next  = data;
                    held_valid_next = 1'b1;
                    xor_next        = xor_reg ^ data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg     <= 1'b0;
            esc_pend_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            xor_reg        <= '0;
            fault_reg      <= 1'b0;
        end else begin
            inside_reg     <= inside_next;
            esc_pend_reg   <= esc_pend_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            xor_reg        <= xor_next;
            fault_reg      <= fault_next;
        end
    end

    sedx_out_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .full     (buf_full),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (rd_res)
    );

    assign m_frame_byte   = rd_res.frame_byte;
    assign m_is_last      = rd_res.is_last;
    assign m_checksum_ok  = rd_res.checksum_ok;
    assign m_escape_fault = rd_res.escape_fault;

`ifndef SYNTHESIS
    a_held_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> inside_reg)
        else $error("held byte outside a frame");

    a_esc_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_pend_reg |-> inside_reg)
        else $error("escape pending outside a frame");

    a_flags_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_last) |-> (!m_checksum_ok && !m_escape_fault))
        else $error("status flags on a beat that is not last");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && inside_reg && s_raw_byte == cfg.sync_value)
        |=> (!inside_reg && !held_valid_reg && !fault_reg))
        else $error("closing sync did not clear the frame state");
`endif

endmodule

/* design/sedx_cfg_regs.sv */
// APB-style register file holding the sync and escape byte values.
// Depends on sedx_pkg for widths, register indexes and reset values.
module sedx_cfg_regs
    import sedx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] escape_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg   <= SYNC_RESET;
            escape_reg <= ESCAPE_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SYNC_IDX:   sync_reg   <= pwdata[BYTE_W-1:0];
                REG_ESCAPE_IDX: escape_reg <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SYNC_IDX:   prdata = {{(DATA_W-BYTE_W){1'b0}}, sync_reg};
            REG_ESCAPE_IDX: prdata = {{(DATA_W-BYTE_W){1'b0}}, escape_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.sync_value   = sync_reg;
    assign cfg.escape_value = escape_reg;

endmodule

/* design/sedx_out_buf.sv */
// Two-entry result buffer that decouples the deframer from a stalled receiver.
// Depends on sedx_pkg for the result type.
module sedx_out_buf
    import sedx_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  res_t wr_data,
    output logic full,
    output logic rd_valid,
    input  logic rd_ready,
    output res_t rd_data
);

    res_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       rd_en;

    assign rd_valid = (count_reg != 2'd0);
    assign full     = count_reg[1];
    assign rd_en    = rd_valid & rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

/* tb/sv/deframer_scoreboard_pkg.sv */
// Scoreboard for the sync/escape deframer: a bit-accurate predictor of the
// frame state and a queue of the frame bytes it expects on the result channel.
// Depends on sedx_pkg for the result type and the escape follower codes.
package deframer_scoreboard_pkg;
    import sedx_pkg::*;

    class deframer_scoreboard;
        logic [BYTE_W-1:0] sync_byte;
        logic [BYTE_W-1:0] escape_byte;
        bit                in_frame;
        bit                esc_pending;
        bit                held_vld;
        logic [BYTE_W-1:0] held;
        logic [BYTE_W-1:0] xor_acc;
        bit                fault;
        res_t              expected_frame_bytes[$];
        int unsigned       errors;
        int unsigned       bytes_checked;
        int unsigned       frames_closed;

        function new();
            sync_byte     = SYNC_RESET;
            escape_byte   = ESCAPE_RESET;
            in_frame      = 1'b0;
            errors        = 0;
            bytes_checked = 0;
            frames_closed = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            esc_pending = 1'b0;
            held_vld    = 1'b0;
            held        = '0;
            xor_acc     = '0;
            fault       = 1'b0;
        endfunction

        function void set_register(logic idx, logic [BYTE_W-1:0] value);
            if (idx == REG_SYNC_IDX) begin
                sync_byte = value;
            end else begin
                escape_byte = value;
            end
        endfunction

        function void release_byte(logic [BYTE_W-1:0] b, bit last, bit ok, bit flt);
            res_t r;
            r.frame_byte   = b;
            r.is_last      = last;
            r.checksum_ok  = ok;
            r.escape_fault = flt;
            expected_frame_bytes.push_back(r);
        endfunction

        function void note_raw_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] data;
            bit                have;
            data = '0;
            have = 1'b0;
            if (!in_frame) begin
                if (b == sync_byte) begin
                    in_frame = 1'b1;
                    clear_frame();
                end
                return;
            end
            if (b == sync_byte) begin
                if (esc_pending) begin
                    fault = 1'b1;
                end
                if (held_vld) begin
                    release_byte(held, 1'b1, xor_acc == '0, fault);
                end
                in_frame = 1'b0;
                clear_frame();
                return;
            end
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (b == ESC_FOLLOW_ESC) begin
                    data = escape_byte;
                    have = 1'b1;
                end else if (b == ESC_FOLLOW_SYNC) begin
                    data = sync_byte;
                    have = 1'b1;
                end else begin
                    fault = 1'b1;
                end
            end else if (b == escape_byte) begin
                esc_pending = 1'b1;
            end else begin
                data = b;
                have = 1'b1;
            end
            if (have) begin
                if (held_vld) begin
                    release_byte(held, 1'b0, 1'b0, 1'b0);
                end
                held     = data;
                held_vld = 1'b1;
                xor_acc  = xor_acc ^ data;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_frame_bytes.size() == 0) begin
                $error("unexpected beat: frame_byte %02h is_last %0b", got.frame_byte,
                       got.is_last);
                errors++;
                return;
            end
            want = expected_frame_bytes.pop_front();
            bytes_checked++;
            if (want.is_last) begin
                frames_closed++;
            end
            if (got.frame_byte !== want.frame_byte) begin
                $error("frame_byte: expected %02h, actual %02h", want.frame_byte,
                       got.frame_byte);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
                errors++;
            end
            if (got.checksum_ok !== want.checksum_ok) begin
                $error("checksum_ok: expected %0b, actual %0b", want.checksum_ok,
                       got.checksum_ok);
                errors++;
            end
            if (got.escape_fault !== want.escape_fault) begin
                $error("escape_fault: expected %0b, actual %0b", want.escape_fault,
                       got.escape_fault);
                errors++;
            end
        endfunction

        function int unsigned pending_count();
            return expected_frame_bytes.size();
        endfunction
    endclass

endpackage

/* tb/sv/sync_escape_deframer_xor_check_test.sv */
// Top-level test of sync_escape_deframer_xor_check: directed and random byte
// streams under several sync/escape settings, checked beat by beat.
// Depends on sedx_pkg, deframer_scoreboard_pkg and the deframer RTL.
module sync_escape_deframer_xor_check_test;
    import sedx_pkg::*;
    import deframer_scoreboard_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned PHASE_BYTES  = 55;
    localparam int unsigned NUM_PHASES   = 6;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_raw_byte;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_frame_byte;
    logic              m_is_last;
    logic              m_checksum_ok;
    logic              m_escape_fault;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    deframer_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned sent_bytes = 0;
    int unsigned settings_used = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    sync_escape_deframer_xor_check uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_raw_byte(s_raw_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame_byte(m_frame_byte),
        .m_is_last(m_is_last), .m_checksum_ok(m_checksum_ok),
        .m_escape_fault(m_escape_fault),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 64);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= cycle_count[2];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_frame_byte, m_is_last, m_checksum_ok, m_escape_fault});
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        s_valid    <= 1'b1;
        s_raw_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_raw_byte(b);
        sent_bytes++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_byte(b);
    endtask

    task automatic push_stuffed(input logic [BYTE_W-1:0] b);
        if (b == sb.sync_byte) begin
            push_byte(sb.escape_byte);
            push_byte(ESC_FOLLOW_SYNC);
        end else if (b == sb.escape_byte) begin
            push_byte(sb.escape_byte);
            push_byte(ESC_FOLLOW_ESC);
        end else begin
            push_byte(b);
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_body_byte();
        case ($urandom_range(0, 7))
            0: return sb.sync_byte;
            1: return sb.escape_byte;
            2: return ESC_FOLLOW_ESC;
            3: return ESC_FOLLOW_SYNC;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_frame();
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] xs;
        int unsigned       len;
        b  = '0;
        xs = '0;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(0, 255)));
        end
        push_byte(sb.sync_byte);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        if ($urandom_range(0, 15) != 0) begin
            repeat (len) begin
                b  = pick_body_byte();
                xs = xs ^ b;
                push_stuffed(b);
            end
            if ($urandom_range(0, 7) == 0) begin
                push_byte(sb.escape_byte);
                push_byte(BYTE_W'($urandom_range(0, 255)));
            end
            push_stuffed(($urandom_range(0, 3) != 0) ? xs : BYTE_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0) begin
            push_byte(sb.escape_byte);
        end
        push_byte(sb.sync_byte);
    endtask

    task automatic drain_results();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [BYTE_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_register(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[BYTE_W-1:0] !== value) begin
            $error("prdata: expected %02h, actual %02h", value, prdata[BYTE_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    logic [BYTE_W-1:0] directed_bytes[] = '{
        8'hFF, 8'h00,
        8'h7E, 8'h01, 8'h7D, 8'h01, 8'h7D, 8'h02, 8'h02, 8'h7E,
        8'h7E, 8'hFF, 8'h00, 8'h7D, 8'h03, 8'h7D, 8'h7D, 8'h7E,
        8'h7E, 8'h11, 8'h7D, 8'h7E,
        8'h7E, 8'h7E,
        8'h7E, 8'h33, 8'h44
    };
    logic [BYTE_W-1:0] phase_sync[NUM_PHASES] = '{8'h7E, 8'h00, 8'hFF, 8'h5A, 8'h01, 8'h00};
    logic [BYTE_W-1:0] phase_escape[NUM_PHASES] = '{8'h7D, 8'hFF, 8'h00, 8'h5A, 8'h02, 8'h00};

    initial begin
        int unsigned phase_start;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_raw_byte = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        phase_sync[NUM_PHASES-1]   = BYTE_W'($urandom_range(0, 255));
        phase_escape[NUM_PHASES-1] = BYTE_W'($urandom_range(0, 255));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // The directed stream ends inside an open frame, so the first register
        // change below lands mid-frame.
        foreach (directed_bytes[i]) begin
            push_byte(directed_bytes[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_register(REG_SYNC_IDX, phase_sync[p]);
            write_register(REG_ESCAPE_IDX, phase_escape[p]);
            settings_used++;
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES) send_random_frame();
        end
        drain_results();
        repeat (8) @(posedge aclk);

        $display("Sent %0d raw bytes over %0d register settings plus reset values.",
                 sent_bytes, settings_used);
        $display("Checked %0d frame bytes, %0d of them closing a frame.",
                 sb.bytes_checked, sb.frames_closed);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
